// ===== sv/prl_pkg.sv =====
// Shared types and codes for the positional record list.
// Holds request/response beat structs, opcode and status codes; no dependencies.
`default_nettype none

package prl_pkg;

   localparam int KEY_BITS     = 32;
   localparam int POS_BITS     = 7;
   localparam int WORD_BITS    = 64;
   localparam int COUNT_BITS   = 7;
   localparam int OPCODE_BITS  = 3;
   localparam int STATUS_BITS  = 3;

   localparam logic [OPCODE_BITS-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_RM_FRONT  = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_RM_BACK   = 3'd4;
   localparam logic [OPCODE_BITS-1:0] OP_RM_POS    = 3'd5;
   localparam logic [OPCODE_BITS-1:0] OP_SEARCH    = 3'd6;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [OPCODE_BITS-1:0]    opcode;
      logic [POS_BITS-1:0]       position;
      logic signed [KEY_BITS-1:0] record_key;
      logic [WORD_BITS-1:0]      record_payload;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   found_payload;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/positional_record_list_unit.sv =====
// Positional record list: ordered list of {key, payload} records in a memory.
// Depends on prl_pkg (beat types, codes) and prl_mem (record store).
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one operation beat:
//   insert front/back/at position, remove front/back/at position, or search
//   by key. rsp channel (rsp_valid/rsp_ready/rsp_data) returns one beat per
//   request with status, found payload and the entry count afterwards.
//   One request is in work at a time; req_ready is high only while idle.
//   Each request runs from S_IDLE to S_DONE; a rejected op (full, empty,
//   bad position, unused opcode) goes straight to S_DONE. An insert at p
//   moves entries len-1 down to p up by one, then writes the new record;
//   a remove at p moves the entries after p down by one; a search stops
//   at the first match. len = entries before the operation.
//   The single memory port pair sets the pace: entries move one per
//   cycle through the registered read port, and the search compares one
//   entry per cycle.
//   A finished result sits in the rsp output register; the next request is
//   taken while it waits, but its own result holds until the slot frees.
//   Synchronous reset empties the list and drops any pending response; the
//   memory itself is not cleared.
`default_nettype none

module positional_record_list_unit #(
   parameter int CAPACITY     = 64,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire prl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output prl_pkg::rsp_type      rsp_data
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMPW  = ((CW > prl_pkg::POS_BITS) ? CW : prl_pkg::POS_BITS) + 1;
   localparam int MW    = prl_pkg::KEY_BITS + PAYLOAD_BITS;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SHIFT  = 4'b0010,
      S_SEARCH = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] left_ff, left_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic          pend_ff, pend_in;
   logic          up_ff, up_in;
   logic [prl_pkg::KEY_BITS-1:0]    key_ff, key_in;
   logic [PAYLOAD_BITS-1:0]         pay_ff, pay_in;
   logic [prl_pkg::STATUS_BITS-1:0] stat_ff, stat_in;
   logic [prl_pkg::WORD_BITS-1:0]   found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   prl_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [MW-1:0] wr_data, rd_data;

   logic [CMPW-1:0] len_w, pos_w;
   logic [AW-1:0]   pos_a;
   logic [prl_pkg::KEY_BITS-1:0] rd_key;
   logic [prl_pkg::WORD_BITS-1:0] rd_pay_wide;

   prl_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (MW),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign len_w  = CMPW'(len_ff);
   assign rd_key = rd_data[MW-1:PAYLOAD_BITS];

   always_comb begin
      rd_pay_wide = '0;
      rd_pay_wide[PAYLOAD_BITS-1:0] = rd_data[PAYLOAD_BITS-1:0];
   end

   // position the request names, in a width that holds both fields
   always_comb begin
      case (req_data.opcode)
         prl_pkg::OP_INS_BACK: pos_w = len_w;
         prl_pkg::OP_RM_BACK:  pos_w = len_w - CMPW'(1);
         prl_pkg::OP_INS_POS,
         prl_pkg::OP_RM_POS:   pos_w = CMPW'(req_data.position);
         default:              pos_w = '0;
      endcase
   end
   assign pos_a = AW'(pos_w);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      ptr_in       = ptr_ff;
      wa_in        = wa_ff;
      pos_in       = pos_ff;
      pend_in      = 1'b0;
      up_in        = up_ff;
      key_in       = key_ff;
      pay_in       = pay_ff;
      stat_in      = stat_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = wa_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_data.record_key;
               pay_in   = req_data.record_payload[PAYLOAD_BITS-1:0];
               pos_in   = pos_a;
               stat_in  = prl_pkg::ST_OK;
               found_in = '0;
               state_in = S_DONE;
               unique case (req_data.opcode) inside
                  prl_pkg::OP_INS_FRONT, prl_pkg::OP_INS_BACK, prl_pkg::OP_INS_POS: begin
                     up_in = 1'b1;
                     if (len_ff == CW'(CAPACITY)) begin
                        stat_in = prl_pkg::ST_FULL;
                     end else if (pos_w > len_w) begin
                        stat_in = prl_pkg::ST_BADPOS;
                     end else begin
                        // move entries len-1 down to pos up by one
                        ptr_in   = AW'(len_ff - CW'(1));
                        left_in  = len_ff - CW'(pos_a);
                        state_in = S_SHIFT;
                     end
                  end
                  prl_pkg::OP_RM_FRONT, prl_pkg::OP_RM_BACK, prl_pkg::OP_RM_POS: begin
                     up_in = 1'b0;
                     if (len_ff == '0) begin
                        stat_in = prl_pkg::ST_EMPTY;
                     end else if (pos_w >= len_w) begin
                        stat_in = prl_pkg::ST_BADPOS;
                     end else begin
                        // move entries pos+1 .. len-1 down by one
                        ptr_in   = pos_a + AW'(1);
                        left_in  = len_ff - CW'(pos_a) - CW'(1);
                        state_in = S_SHIFT;
                     end
                  end
                  prl_pkg::OP_SEARCH: begin
                     if (len_ff == '0) begin
                        stat_in = prl_pkg::ST_NOTFOUND;
                     end else begin
                        ptr_in   = '0;
                        left_in  = len_ff;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = rd_data;
            end
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff;
               pend_in = 1'b1;
               wa_in   = up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
               ptr_in  = up_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
               left_in = left_ff - CW'(1);
            end else if (!pend_ff) begin
               // all moves written; port is free for the new record
               if (up_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pos_ff;
                  wr_data = {key_ff, pay_ff};
                  len_in  = len_ff + CW'(1);
               end else begin
                  len_in  = len_ff - CW'(1);
               end
               state_in = S_DONE;
            end
         end

         S_SEARCH: begin
            if (pend_ff && (rd_key == key_ff)) begin
               found_in = rd_pay_wide;
               stat_in  = prl_pkg::ST_OK;
               state_in = S_DONE;
            end else if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff;
               pend_in = 1'b1;
               ptr_in  = ptr_ff + AW'(1);
               left_in = left_ff - CW'(1);
            end else begin
               stat_in  = prl_pkg::ST_NOTFOUND;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status        = stat_ff;
               rsp_in.found_payload = found_ff;
               rsp_in.entry_count   = prl_pkg::COUNT_BITS'(len_ff);
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      ptr_ff   <= ptr_in;
      wa_ff    <= wa_in;
      pos_ff   <= pos_in;
      up_ff    <= up_in;
      key_ff   <= key_in;
      pay_ff   <= pay_in;
      stat_ff  <= stat_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== sv/prl_mem.sv =====
// Record store: one write port, one read port with registered read data.
// Generic; no package dependency.
`default_nettype none

module prl_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 96,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== bench/positional_record_list_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for positional_record_list_unit: directed and random list operations.
// Depends on prl_pkg and the unit's RTL; a shadow list predicts every response beat.

module positional_record_list_unit_test;

   localparam int CAPACITY     = 64;
   localparam int PAYLOAD_BITS = 64;
   localparam int MAX_IDLE     = 13;
   localparam int SETTLE_CYCLES = 100;
   localparam int DRAIN_LIMIT  = 5000;
   localparam logic [prl_pkg::OPCODE_BITS-1:0] OP_UNUSED = 3'd7;
   localparam logic [prl_pkg::WORD_BITS-1:0] PAYLOAD_MASK =
      {prl_pkg::WORD_BITS{1'b1}} >> (prl_pkg::WORD_BITS - PAYLOAD_BITS);

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   prl_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   prl_pkg::rsp_type rsp_data;

   // shadow copy of the list contents, index 0 is the front
   logic [prl_pkg::KEY_BITS-1:0]  list_keys[$];
   logic [prl_pkg::WORD_BITS-1:0] list_payloads[$];
   prl_pkg::rsp_type              pending_outcomes[$];

   int send_gap_max   = 0;
   int recv_stall_max = 0;
   int error_count    = 0;
   int beats_sent     = 0;
   int beats_checked  = 0;
   int search_hits    = 0;
   int peak_length    = 0;
   int status_seen[8];

   positional_record_list_unit #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   // ---------------- prediction ----------------

   function automatic logic [prl_pkg::STATUS_BITS-1:0] shadow_insert(
      input int slot, input prl_pkg::req_type op);
      if (list_keys.size() >= CAPACITY) return prl_pkg::ST_FULL;
      if (slot > list_keys.size()) return prl_pkg::ST_BADPOS;
      list_keys.insert(slot, op.record_key);
      list_payloads.insert(slot, op.record_payload & PAYLOAD_MASK);
      return prl_pkg::ST_OK;
   endfunction

   function automatic logic [prl_pkg::STATUS_BITS-1:0] shadow_remove(input int slot);
      // empty is checked before position
      if (list_keys.size() == 0) return prl_pkg::ST_EMPTY;
      if (slot >= list_keys.size()) return prl_pkg::ST_BADPOS;
      list_keys.delete(slot);
      list_payloads.delete(slot);
      return prl_pkg::ST_OK;
   endfunction

   function automatic prl_pkg::rsp_type apply_list_op(input prl_pkg::req_type op);
      prl_pkg::rsp_type outcome;
      outcome = '0;
      outcome.status = prl_pkg::ST_OK;
      case (op.opcode)
         prl_pkg::OP_INS_FRONT: outcome.status = shadow_insert(0, op);
         prl_pkg::OP_INS_BACK:  outcome.status = shadow_insert(list_keys.size(), op);
         prl_pkg::OP_INS_POS:   outcome.status = shadow_insert(int'(op.position), op);
         prl_pkg::OP_RM_FRONT:  outcome.status = shadow_remove(0);
         prl_pkg::OP_RM_BACK:   outcome.status = shadow_remove(list_keys.size() - 1);
         prl_pkg::OP_RM_POS:    outcome.status = shadow_remove(int'(op.position));
         prl_pkg::OP_SEARCH: begin
            outcome.status = prl_pkg::ST_NOTFOUND;
            for (int i = 0; i < list_keys.size(); i++) begin
               if (outcome.status == prl_pkg::ST_NOTFOUND &&
                   list_keys[i] == op.record_key) begin
                  outcome.status        = prl_pkg::ST_OK;
                  outcome.found_payload = list_payloads[i];
               end
            end
         end
         default: ;  // unused opcode: no change, status ok
      endcase
      outcome.entry_count = prl_pkg::COUNT_BITS'(list_keys.size());
      return outcome;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic prl_pkg::req_type make_op(
      input logic [prl_pkg::OPCODE_BITS-1:0] code,
      input logic [prl_pkg::POS_BITS-1:0]    slot,
      input logic [prl_pkg::KEY_BITS-1:0]    key,
      input logic [prl_pkg::WORD_BITS-1:0]   word);
      prl_pkg::req_type op;
      op.opcode         = code;
      op.position       = slot;
      op.record_key     = key;
      op.record_payload = word;
      return op;
   endfunction

   function automatic logic [prl_pkg::WORD_BITS-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // small key pool gives duplicate keys and search hits
   function automatic logic [prl_pkg::KEY_BITS-1:0] pick_key();
      if ($urandom_range(0, 2) == 0) begin
         return prl_pkg::KEY_BITS'($urandom_range(0, 15)) - prl_pkg::KEY_BITS'(8);
      end
      return $urandom;
   endfunction

   function automatic logic [prl_pkg::KEY_BITS-1:0] pick_search_key();
      if (list_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
         return list_keys[$urandom_range(0, list_keys.size() - 1)];
      end
      return pick_key();
   endfunction

   function automatic prl_pkg::req_type random_insert();
      logic [prl_pkg::OPCODE_BITS-1:0] code;
      logic [prl_pkg::POS_BITS-1:0]    slot;
      case ($urandom_range(0, 2))
         0:       code = prl_pkg::OP_INS_FRONT;
         1:       code = prl_pkg::OP_INS_BACK;
         default: code = prl_pkg::OP_INS_POS;
      endcase
      if ($urandom_range(0, 6) != 0) begin
         slot = prl_pkg::POS_BITS'($urandom_range(0, list_keys.size()));
      end else begin
         slot = prl_pkg::POS_BITS'($urandom_range(0, 127));
      end
      return make_op(code, slot, pick_key(), rand_word());
   endfunction

   function automatic prl_pkg::req_type random_remove();
      logic [prl_pkg::OPCODE_BITS-1:0] code;
      logic [prl_pkg::POS_BITS-1:0]    slot;
      case ($urandom_range(0, 2))
         0:       code = prl_pkg::OP_RM_FRONT;
         1:       code = prl_pkg::OP_RM_BACK;
         default: code = prl_pkg::OP_RM_POS;
      endcase
      if (list_keys.size() > 0 && $urandom_range(0, 6) != 0) begin
         slot = prl_pkg::POS_BITS'($urandom_range(0, list_keys.size() - 1));
      end else begin
         slot = prl_pkg::POS_BITS'($urandom_range(0, 127));
      end
      return make_op(code, slot, pick_key(), rand_word());
   endfunction

   function automatic void choose_idle_profile();
      case ($urandom_range(0, 3))
         0:       begin send_gap_max = 0;        recv_stall_max = 0;        end
         1:       begin send_gap_max = MAX_IDLE; recv_stall_max = 0;        end
         2:       begin send_gap_max = 0;        recv_stall_max = MAX_IDLE; end
         default: begin send_gap_max = MAX_IDLE; recv_stall_max = MAX_IDLE; end
      endcase
   endfunction

   // one request beat; valid stays high into the next call when no gap is drawn
   task automatic send_op(input prl_pkg::req_type op);
      int               gap;
      prl_pkg::rsp_type outcome;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= op;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      outcome = apply_list_op(op);
      pending_outcomes.push_back(outcome);
      beats_sent++;
      status_seen[int'(outcome.status)]++;
      if (op.opcode == prl_pkg::OP_SEARCH && outcome.status == prl_pkg::ST_OK) search_hits++;
      if (list_keys.size() > peak_length) peak_length = list_keys.size();
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_empty_list();
      send_gap_max   = 0;
      recv_stall_max = 0;
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,   32'd0, 64'd0));
      send_op(make_op(prl_pkg::OP_RM_FRONT,  7'd0,   32'd0, 64'd0));
      send_op(make_op(prl_pkg::OP_RM_BACK,   7'd0,   32'd0, 64'd0));
      send_op(make_op(prl_pkg::OP_RM_POS,    7'd127, 32'd0, 64'd0));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd1,   32'd5, 64'd9));
      send_op(make_op(OP_UNUSED,             7'd127, '1,    '1));
   endtask

   task automatic test_edges();
      send_gap_max   = MAX_IDLE;
      recv_stall_max = MAX_IDLE;
      send_op(make_op(prl_pkg::OP_INS_BACK,  7'd0,  32'h7FFF_FFFF, '1));
      send_op(make_op(prl_pkg::OP_INS_FRONT, 7'd0,  32'h8000_0000, 64'd0));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd1,  32'hFFFF_FFFF, 64'hA5A5_A5A5_A5A5_A5A5));
      // position equal to length appends
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd3,  32'd0,         64'h5A5A_5A5A_5A5A_5A5A));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd5,  32'd1,         64'd1));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd64, 32'd1,         64'd1));
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,  32'hFFFF_FFFF, 64'd0));
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,  32'h8000_0000, 64'd0));
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,  32'h7FFF_FFFF, 64'd0));
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,  32'd12345,     64'd0));
      // duplicate key: search must return the first one
      send_op(make_op(prl_pkg::OP_INS_BACK,  7'd0,  32'hFFFF_FFFF, 64'd1));
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,  32'hFFFF_FFFF, '1));
      send_op(make_op(prl_pkg::OP_RM_POS,    7'd5,  32'd0,         64'd0));
      send_op(make_op(prl_pkg::OP_RM_POS,    7'd2,  32'd0,         64'd0));
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,  32'hFFFF_FFFF, 64'd0));
      send_op(make_op(prl_pkg::OP_RM_FRONT,  7'd0,  32'd0,         64'd0));
      send_op(make_op(prl_pkg::OP_RM_BACK,   7'd0,  32'd0,         64'd0));
      send_op(make_op(OP_UNUSED,             7'd3,  32'd7,         64'd7));
      hold_until_drained();
   endtask

   task automatic test_capacity();
      send_gap_max   = 0;
      recv_stall_max = 0;
      while (list_keys.size() < CAPACITY) send_op(random_insert());
      send_op(make_op(prl_pkg::OP_INS_FRONT, 7'd0,   pick_key(), rand_word()));
      send_op(make_op(prl_pkg::OP_INS_BACK,  7'd0,   pick_key(), rand_word()));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd0,   pick_key(), rand_word()));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd64,  pick_key(), rand_word()));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd127, pick_key(), rand_word()));
      // search for the last entry's key, which can walk the whole list
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,   list_keys[CAPACITY-1], 64'd0));
      send_op(make_op(prl_pkg::OP_SEARCH,    7'd0,   $urandom, 64'd0));
      send_op(make_op(prl_pkg::OP_RM_POS,    7'd64,  32'd0, 64'd0));
      send_op(make_op(prl_pkg::OP_RM_POS,    7'd63,  32'd0, 64'd0));
      send_op(make_op(prl_pkg::OP_INS_POS,   7'd63,  pick_key(), rand_word()));
      send_op(make_op(prl_pkg::OP_RM_POS,    7'd127, 32'd0, 64'd0));
      hold_until_drained();
      send_gap_max   = MAX_IDLE;
      recv_stall_max = MAX_IDLE;
      while (list_keys.size() > 0) send_op(random_remove());
      send_op(make_op(prl_pkg::OP_RM_BACK,   7'd0,   32'd0, 64'd0));
      hold_until_drained();
   endtask

   task automatic test_random_mix(input int count);
      int grow_pct;
      int pick;
      grow_pct = 70;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) choose_idle_profile();
         // swing the length between empty and full
         if (list_keys.size() >= CAPACITY) grow_pct = 30;
         else if (list_keys.size() == 0) grow_pct = 70;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_op(make_op(OP_UNUSED, prl_pkg::POS_BITS'($urandom), $urandom, rand_word()));
         end else if (pick < 30) begin
            send_op(make_op(prl_pkg::OP_SEARCH, prl_pkg::POS_BITS'($urandom),
                            pick_search_key(), rand_word()));
         end else if ($urandom_range(0, 99) < grow_pct) begin
            send_op(random_insert());
         end else begin
            send_op(random_remove());
         end
      end
      hold_until_drained();
   endtask

   // ---------------- response side ----------------

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, recv_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      prl_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response beat with nothing outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_data.status !== want.status) begin
               report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                         beats_checked, rsp_data.status, want.status));
            end
            if (rsp_data.found_payload !== want.found_payload) begin
               report_mismatch($sformatf("beat %0d found_payload got %h want %h",
                                         beats_checked, rsp_data.found_payload,
                                         want.found_payload));
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               report_mismatch($sformatf("beat %0d entry_count got %0d want %0d",
                                         beats_checked, rsp_data.entry_count,
                                         want.entry_count));
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int wait_cycles;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_edges();
      test_capacity();
      test_random_mix(330);

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_outcomes.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         report_mismatch($sformatf("%0d response beats never arrived",
                                   pending_outcomes.size()));
      end

      $display("ran %0d request beats, checked %0d response beats, peak list length %0d",
               beats_sent, beats_checked, peak_length);
      $display("search hits %0d, full %0d, empty %0d, bad position %0d, not found %0d",
               search_hits, status_seen[int'(prl_pkg::ST_FULL)],
               status_seen[int'(prl_pkg::ST_EMPTY)],
               status_seen[int'(prl_pkg::ST_BADPOS)],
               status_seen[int'(prl_pkg::ST_NOTFOUND)]);
      if (error_count == 0) begin
         $display("** positional_record_list_unit: PASSED **");
      end else begin
         $display("** positional_record_list_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting on the unit");
      $display("** positional_record_list_unit: FAILED **");
      $finish;
   end

endmodule
